/* design/sdd_pkg.sv */
`default_nettype none
package sdd_pkg;

   // Largest year taken as a valid date.
   localparam int MAX_YEAR = 9999;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int DN_W    = 23;            // day number up to year 16383
   localparam int DIFF_W  = 23;            // result width
   localparam int WIDE_W  = DN_W + 1;      // raw signed difference

   // Saturation bound of the result
   localparam logic signed [WIDE_W-1:0] OUT_LIMIT = 24'sd4194303;

   // x/25 == (x * RECIP_25) >> RECIP_SH, exact for x < 4096
   localparam int RECIP_25 = 5243;
   localparam int RECIP_SH = 17;

   // Leap year in terms of p = year - 1
   localparam logic [YEAR_W-1:0] REM_100_LAST = 14'd99;
   localparam logic [YEAR_W-1:0] REM_400_LAST = 14'd399;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [YEAR_W-1:0]  p;       // year - 1
      logic [7:0]         pd100;   // p / 100
      logic [5:0]         pd400;   // p / 400
      logic [8:0]         cum;     // days before month, common year
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic               yr_ok;
      logic               mo_ok;
   } s1_date_type;

   typedef struct packed {
      logic [DN_W-1:0]    mul365;  // p * 365
      logic [11:0]        q4;      // p / 4
      logic [7:0]         pd100;
      logic [5:0]         pd400;
      logic [8:0]         cum;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic               leap;
      logic               yr_ok;
      logic               mo_ok;
   } s2_date_type;

   typedef struct packed {
      logic [DN_W-1:0] dn;
      logic            ok;
   } s3_date_type;

   // Days before the first of month m in a common year.
   function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
      logic [8:0] r;
      case (m)
         4'd1:    r = 9'd0;
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] r;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
         4'd2:    r = leap ? 5'd29 : 5'd28;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* design/signed_day_difference.sv */
`default_nettype none
// signed_day_difference: signed day count between two Gregorian dates.
// Response: an accepted req beat passes stage registers 1, 2, 3 and 4; rsp_valid is the stage 4 valid bit.
// Throughput: one beat per cycle; four-stage pipeline with per-stage
//   valid bits, each stage holds while the one after it is full and stalled.
// Reset: synchronous, active high; clears all stage valid bits only.
module signed_day_difference
   import sdd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [YEAR_W-1:0]        req_first_year,
   input  wire logic [MONTH_W-1:0]       req_first_month,
   input  wire logic [DAY_W-1:0]         req_first_day,
   input  wire logic [YEAR_W-1:0]        req_second_year,
   input  wire logic [MONTH_W-1:0]       req_second_month,
   input  wire logic [DAY_W-1:0]         req_second_day,
   input  wire logic                     req_include_last,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DIFF_W-1:0]      rsp_day_difference,
   output logic                          rsp_bad_date
);

   // ---------------------------------------------------------------
   // Pipeline control. Stage k loads when it is empty or when stage
   // k+1 is about to take its beat.
   // ---------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4      = !v4_ff || rsp_ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   assign v1_in = rdy1 ? req_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff     : v2_ff;
   assign v3_in = rdy3 ? v2_ff     : v3_ff;
   assign v4_in = rdy4 ? v3_ff     : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: p = year - 1, p/100 and p/400 by reciprocal multiply,
   // month table lookup, range checks on year and month.
   // ---------------------------------------------------------------
   s1_date_type s1_ff [2];
   s1_date_type s1_in [2];
   logic        inc1_ff, inc1_in;

   always_comb begin
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      logic [YEAR_W-1:0]  p;
      logic [24:0]        prod100;
      logic [22:0]        prod400;
      for (int i = 0; i < 2; i++) begin
         y = (i == 0) ? req_first_year  : req_second_year;
         m = (i == 0) ? req_first_month : req_second_month;
         d = (i == 0) ? req_first_day   : req_second_day;
         p = y - 14'd1;
         // p/100 = (p/4)/25, p/400 = (p/16)/25
         prod100 = 25'(p[YEAR_W-1:2]) * 25'(RECIP_25);
         prod400 = 23'(p[YEAR_W-1:4]) * 23'(RECIP_25);
         s1_in[i].p     = p;
         s1_in[i].pd100 = prod100[24:RECIP_SH];
         s1_in[i].pd400 = prod400[22:RECIP_SH];
         s1_in[i].cum   = cum_days(m);
         s1_in[i].month = m;
         s1_in[i].day   = d;
         s1_in[i].yr_ok = (y != '0) && (32'(y) <= MAX_YEAR);
         s1_in[i].mo_ok = (m >= MONTH_JAN) && (m <= MONTH_DEC);
      end
   end
   assign inc1_in = req_include_last;

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         s1_ff   <= s1_in;
         inc1_ff <= inc1_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: p*365 and the leap flag from p mod 100 / p mod 400.
   // year is leap when p%400 == 399, or p%4 == 3 and p%100 != 99.
   // ---------------------------------------------------------------
   s2_date_type s2_ff [2];
   s2_date_type s2_in [2];
   logic        inc2_ff, inc2_in;

   always_comb begin
      logic [YEAR_W-1:0] rem100;
      logic [YEAR_W-1:0] rem400;
      for (int i = 0; i < 2; i++) begin
         rem100 = s1_ff[i].p - 14'(s1_ff[i].pd100) * 14'd100;
         rem400 = s1_ff[i].p - 14'(s1_ff[i].pd400) * 14'd400;
         s2_in[i].mul365 = 23'(s1_ff[i].p) * 23'd365;
         s2_in[i].q4     = s1_ff[i].p[YEAR_W-1:2];
         s2_in[i].pd100  = s1_ff[i].pd100;
         s2_in[i].pd400  = s1_ff[i].pd400;
         s2_in[i].cum    = s1_ff[i].cum;
         s2_in[i].month  = s1_ff[i].month;
         s2_in[i].day    = s1_ff[i].day;
         s2_in[i].leap   = (rem400 == REM_400_LAST) ||
                           ((s1_ff[i].p[1:0] == 2'b11) && (rem100 != REM_100_LAST));
         s2_in[i].yr_ok  = s1_ff[i].yr_ok;
         s2_in[i].mo_ok  = s1_ff[i].mo_ok;
      end
   end
   assign inc2_in = inc1_ff;

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         s2_ff   <= s2_in;
         inc2_ff <= inc2_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: day number sum (0001-01-01 is day 1) and day-of-month
   // check, which needs the leap flag for February.
   // ---------------------------------------------------------------
   s3_date_type s3_ff [2];
   s3_date_type s3_in [2];
   logic        inc3_ff, inc3_in;

   always_comb begin
      logic leap_adj;
      for (int i = 0; i < 2; i++) begin
         leap_adj = s2_ff[i].leap && (s2_ff[i].month > MONTH_FEB);
         s3_in[i].dn = s2_ff[i].mul365 + 23'(s2_ff[i].q4) - 23'(s2_ff[i].pd100)
                     + 23'(s2_ff[i].pd400) + 23'(s2_ff[i].cum)
                     + 23'(s2_ff[i].day) + 23'(leap_adj);
         s3_in[i].ok = s2_ff[i].yr_ok && s2_ff[i].mo_ok && (s2_ff[i].day != '0) &&
                       (s2_ff[i].day <= month_len(s2_ff[i].month, s2_ff[i].leap));
      end
   end
   assign inc3_in = inc2_ff;

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         s3_ff   <= s3_in;
         inc3_ff <= inc3_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4 (output register): signed difference, include-last adds
   // one to the magnitude (equal dates count as non-negative), then
   // saturate. A bad date forces zero.
   // ---------------------------------------------------------------
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic                     bad_ff, bad_in;

   always_comb begin
      logic signed [WIDE_W-1:0] raw;
      logic signed [WIDE_W-1:0] adj;
      raw = $signed({1'b0, s3_ff[1].dn}) - $signed({1'b0, s3_ff[0].dn});
      if (raw >= 0) begin
         adj = raw + WIDE_W'(inc3_ff);
      end else begin
         adj = raw - WIDE_W'(inc3_ff);
      end
      if (adj > OUT_LIMIT) begin
         adj = OUT_LIMIT;
      end else if (adj < -OUT_LIMIT) begin
         adj = -OUT_LIMIT;
      end
      bad_in  = !(s3_ff[0].ok && s3_ff[1].ok);
      diff_in = bad_in ? '0 : adj[DIFF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         diff_ff <= diff_in;
         bad_ff  <= bad_in;
      end
   end

   assign rsp_valid          = v4_ff;
   assign rsp_day_difference = diff_ff;
   assign rsp_bad_date       = bad_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   // a flagged beat always carries a zero count
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_date |-> rsp_day_difference == '0)
      else $error("bad date beat with nonzero count");

   // an accepted beat lands in stage 1
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> v1_ff)
      else $error("accepted beat lost at stage 1");

   // full and stalled pipeline must back-pressure the input
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      v1_ff && v2_ff && v3_ff && v4_ff && !rsp_ready |-> !req_ready)
      else $error("input taken while pipeline full and stalled");

   // a stalled output beat keeps the stage behind it from advancing
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      v3_ff && v4_ff && !rsp_ready |=> v3_ff && $stable(s3_ff[0].dn))
      else $error("stage 3 moved under an output stall");

endmodule
`default_nettype wire
